// File: sv/tlve_pkg.sv
// Shared constants and codes for the tank level and volume estimator.
// No dependencies; imported by tank_level_volume_estimator.
`timescale 1ns / 1ps

package tlve_pkg;

    localparam int MaxHeightCm = 255;
    localparam int DivW        = 64;              // divider dividend width
    localparam int DivSteps    = DivW;
    localparam logic [17:0] PiQ16     = 18'd205887;
    localparam int          PiBits    = 18;
    localparam logic [15:0] VolDivLo  = 16'd12000; // volume divisor over 2^24
    localparam logic [64:0] VolRound  = 65'd100663296000; // half of 12000*2^24
    localparam logic [25:0] DipLow    = 26'd5120;
    localparam logic [25:0] DipHigh   = 26'd6144;
    localparam logic [14:0] PctMax    = 15'd25600;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_TOOCLOSE = 3'd1,
        ST_JUMP     = 3'd2,
        ST_SAME     = 3'd3,
        ST_DIP      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        REG_TOP  = 2'd0,
        REG_BASE = 2'd1,
        REG_TANK = 2'd2,
        REG_OFF  = 2'd3
    } t_reg_idx;

endpackage

// File: sv/tank_level_volume_estimator.sv
// Tank level and volume estimator: top level with sequencer and datapath.
// Depends on tlve_pkg.
`timescale 1ns / 1ps

// Usage
//   Input stream s_axis: one distance reading (Q12.4 cm) per transaction.
//   Output stream m_axis: one result per reading; tuser carries the status,
//   tdata the stored percent, volume and height after the reading.
//   APB port: four registers at byte addresses 0, 4, 8, 12 (top diameter,
//   base diameter, tank height, sensor offset); write only while idle.
// Sequence
//   Rejected and empty-tank readings go from idle straight to the result
//   step. A full computation first runs the slice loop over n slices (up
//   to 255), then divides for T, multiplies by pi and divides for volume.
//   The slice loop shares one 18x18 multiplier; the quotients come from a
//   one-bit-per-cycle restoring divider (64 steps) used three times.
// Flow
//   One reading in flight at a time; s_axis_tready is high only when the
//   sequencer is idle. The next reading may be taken while a result waits.
// Reset
//   Synchronous, active low: registers return to their defaults, stored
//   values and the last reading clear, and the output goes empty.
// Stall
//   If m_axis_tready is held low the sequencer holds at its last step until
//   the output register is free.
module tank_level_volume_estimator
    import tlve_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] distance
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [14:0] level_percent, [40:15] volume,
                                        // [52:41] water_height, [55:53] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_SQ0, S_MULA, S_MULB, S_ACC,
        S_DIVT, S_MULC, S_DIVV, S_DIVP, S_DONE
    } t_state;

    t_state      r_state;
    logic [9:0]  r_top, r_base;
    logic [7:0]  r_tank, r_off;
    logic [15:0] r_last;
    logic [25:0] r_svol;
    logic [11:0] r_sh;
    logic [14:0] r_spct;

    t_status     r_status;
    logic [11:0] r_h;
    logic [7:0]  r_n, r_i;
    logic [17:0] r_e;
    logic [35:0] r_sq, r_p1, r_p2;
    logic [45:0] r_s;
    logic [DivW-1:0] r_dq;
    logic [16:0] r_rem;
    logic [15:0] r_dvs;
    logic [5:0]  r_dcnt;
    logic [4:0]  r_mcnt;
    logic [64:0] r_x;
    logic [63:0] r_msh;
    logic [25:0] r_vol;
    logic [14:0] r_pct;

    logic        r_ovalid;
    logic [55:0] r_odata;
    logic [2:0]  r_ouser;

    // APB
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_TOP:  prdata = {22'd0, r_top};
            REG_BASE: prdata = {22'd0, r_base};
            REG_TANK: prdata = {24'd0, r_tank};
            REG_OFF:  prdata = {24'd0, r_off};
            default:  prdata = 32'd0;
        endcase
    end

    // Input checks
    logic [11:0] off16, tank16;
    logic [15:0] hw, diff;
    logic [19:0] diff10;
    logic        too_close, jump;
    logic [11:0] h_new;
    assign off16     = {r_off, 4'd0};
    assign tank16    = {r_tank, 4'd0};
    assign too_close = s_axis_tdata < {4'd0, off16};
    assign hw        = s_axis_tdata - {4'd0, off16};
    assign diff      = (s_axis_tdata > r_last) ? s_axis_tdata - r_last
                                               : r_last - s_axis_tdata;
    assign diff10    = {1'b0, diff, 3'd0} + {3'd0, diff, 1'b0};
    assign jump      = (r_last != 16'd0) && (diff10 > {4'd0, r_last});
    assign h_new     = ({4'd0, tank16} > hw) ? tank16 - hw[11:0] : 12'd0;

    // Slice arithmetic: one multiplier, operands picked by the step
    logic signed [10:0] delta;
    logic [17:0] e2;
    logic [17:0] mul_a, mul_b;
    logic [35:0] mul_p;
    logic [45:0] s_next;
    assign delta  = $signed({1'b0, r_top}) - $signed({1'b0, r_base});
    assign e2     = r_e + {{7{delta[10]}}, delta};
    assign mul_a  = (r_state == S_MULB) ? e2 : r_e;
    assign mul_b  = (r_state == S_SQ0) ? r_e : e2;
    assign mul_p  = mul_a * mul_b;
    assign s_next = r_s + {10'd0, r_sq} + {10'd0, r_p1} + {10'd0, r_p2};

    // Restoring divider step
    logic [16:0] rem_sh, rem_next;
    logic        qbit;
    logic [DivW-1:0] dq_next;
    assign rem_sh   = {r_rem[15:0], r_dq[DivW-1]};
    assign qbit     = rem_sh >= {1'b0, r_dvs};
    assign rem_next = qbit ? rem_sh - {1'b0, r_dvs} : rem_sh;
    assign dq_next  = {r_dq[DivW-2:0], qbit};

    // Shift-and-add step by the constant pi in Q16
    logic [64:0] x_next;
    assign x_next = PiQ16[r_mcnt] ? r_x + {1'b0, r_msh} : r_x;

    logic [22:0] pct_num;
    assign pct_num = {1'b0, r_h, 10'd0} + {2'b0, r_h, 9'd0} + {5'd0, r_h, 6'd0}
                     + {16'd0, r_tank[7:1]};

    logic out_free;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_top    <= 10'd100;
            r_base   <= 10'd100;
            r_tank   <= 8'd100;
            r_off    <= 8'd0;
            r_last   <= 16'd0;
            r_svol   <= 26'd0;
            r_sh     <= 12'd0;
            r_spct   <= 15'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (t_reg_idx'(paddr[3:2]))
                    REG_TOP:  r_top  <= pwdata[9:0];
                    REG_BASE: r_base <= pwdata[9:0];
                    REG_TANK: r_tank <= pwdata[7:0];
                    REG_OFF:  r_off  <= pwdata[7:0];
                    default:  ;
                endcase
            end
            // load a new result, else drop the one just taken
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_h   <= h_new;
                        r_vol <= 26'd0;
                        r_pct <= 15'd0;
                        if (too_close) begin
                            r_status <= ST_TOOCLOSE;
                            r_state  <= S_DONE;
                        end else if (jump) begin
                            r_status <= ST_JUMP;
                            r_state  <= S_DONE;
                        end else begin
                            r_last   <= s_axis_tdata;
                            r_status <= ST_UPDATED;
                            // empty tank: volume and percent stay zero
                            r_state  <= (h_new == 12'd0) ? S_DONE : S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    // slices = ceil(h/16), never beyond the tank height
                    r_n     <= 8'((13'(r_h) + 13'd15) >> 4);
                    r_i     <= 8'd0;
                    r_s     <= 46'd0;
                    r_e     <= {8'd0, r_base} * {10'd0, r_tank};
                    r_state <= S_SQ0;
                end
                S_SQ0: begin
                    r_sq    <= mul_p;
                    r_state <= S_MULA;
                end
                S_MULA: begin
                    r_p1    <= mul_p;
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_p2    <= mul_p;
                    r_e     <= e2;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_s  <= s_next;
                    r_sq <= r_p2;
                    r_i  <= r_i + 8'd1;
                    if (r_i + 8'd1 == r_n) begin
                        // load the divider for T = (S << 16) / H^2
                        r_dq    <= {2'd0, s_next, 16'd0};
                        r_rem   <= 17'd0;
                        r_dvs   <= {8'd0, r_tank} * {8'd0, r_tank};
                        r_dcnt  <= 6'd0;
                        r_state <= S_DIVT;
                    end else begin
                        r_state <= S_MULA;
                    end
                end
                S_DIVT: begin
                    r_dq   <= dq_next;
                    r_rem  <= rem_next;
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'(DivSteps - 1)) begin
                        // start the product from the rounding half
                        r_msh   <= dq_next;
                        r_x     <= VolRound;
                        r_mcnt  <= 5'd0;
                        r_state <= S_MULC;
                    end
                end
                S_MULC: begin
                    r_x    <= x_next;
                    r_msh  <= {r_msh[62:0], 1'b0};
                    r_mcnt <= r_mcnt + 5'd1;
                    if (r_mcnt == 5'(PiBits - 1)) begin
                        // drop the 2^24 part of the divisor, then divide by 12000
                        r_dq    <= {23'd0, x_next[64:24]};
                        r_rem   <= 17'd0;
                        r_dvs   <= VolDivLo;
                        r_dcnt  <= 6'd0;
                        r_state <= S_DIVV;
                    end
                end
                S_DIVV: begin
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'(DivSteps - 1)) begin
                        r_vol   <= dq_next[25:0];
                        r_dq    <= {41'd0, pct_num};
                        r_rem   <= 17'd0;
                        r_dvs   <= {8'd0, r_tank};
                        r_state <= S_DIVP;
                    end else begin
                        r_dq  <= dq_next;
                        r_rem <= rem_next;
                    end
                end
                S_DIVP: begin
                    r_dq   <= dq_next;
                    r_rem  <= rem_next;
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'(DivSteps - 1)) begin
                        r_pct   <= (dq_next > {49'd0, PctMax}) ? PctMax : dq_next[14:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        if (r_status != ST_UPDATED) begin
                            r_ouser <= r_status;
                            r_odata <= {3'd0, r_sh, r_svol, r_spct};
                        end else if (r_vol == r_svol) begin
                            r_ouser <= ST_SAME;
                            r_odata <= {3'd0, r_sh, r_svol, r_spct};
                        end else if (r_vol < r_svol && (r_svol - r_vol) > DipLow
                                     && (r_svol - r_vol) < DipHigh) begin
                            r_ouser <= ST_DIP;
                            r_odata <= {3'd0, r_sh, r_svol, r_spct};
                        end else begin
                            r_ouser <= ST_UPDATED;
                            r_odata <= {3'd0, r_h, r_vol, r_pct};
                            r_sh    <= r_h;
                            r_svol  <= r_vol;
                            r_spct  <= r_pct;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
